// ===== rtl/ssfs_pkg.sv =====
// Shared types, constants and the digit font for the seven-segment frame sequencer.
`timescale 1ns / 1ps

package ssfs_pkg;

    // Request commands, carried in tuser
    localparam logic [1:0] CMD_SLEEP   = 2'd0;
    localparam logic [1:0] CMD_DEFAULT = 2'd1;
    localparam logic [1:0] CMD_SELECT  = 2'd2;
    localparam logic [1:0] CMD_MATCH   = 2'd3;

    // Digit selects
    localparam logic [7:0] SEL_START = 8'h08;
    localparam logic [7:0] SEL_UNIT  = 8'h01;
    localparam logic [7:0] SEL_NONE  = 8'h00;

    // Active-low segment patterns, dp at bit 7, gfedcba below
    localparam logic [7:0] SEG_DASH       = 8'hBF;
    localparam logic [7:0] SEG_UNDERSCORE = 8'hF7;
    localparam logic [7:0] SEG_DOT        = 8'h7F;
    localparam logic [7:0] SEG_BLANK      = 8'hFF;

    // Reciprocal of ten: q = (v * RECIP10) >> RECIP_SHIFT is exact for 16-bit v
    localparam logic [15:0] RECIP10     = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DASH,
        ST_LEAD,
        ST_DIGIT,
        ST_BLANK
    } t_state;

    typedef enum logic [1:0] {
        FRAME_DASH,
        FRAME_LEAD,
        FRAME_DIGIT,
        FRAME_BLANK
    } t_frame;

    // Controller to datapath commands
    typedef struct packed {
        logic   load;   // capture a new request
        logic   emit;   // write a frame into the output register
        t_frame frame;  // which frame to write
    } t_ctrl;

    // Datapath to controller status
    typedef struct packed {
        logic       out_free;    // output register can take a frame this cycle
        logic       value_zero;  // working value is zero
        logic       quot_zero;   // working value divided by ten is zero
        logic       sel_unit;    // select has reached the rightmost digit
        logic [1:0] cmd;         // command on the request input, not the captured one
    } t_stat;

    // Common-anode font for decimal digits
    function automatic logic [7:0] digit_font(input logic [3:0] d);
        logic [7:0] seg;
        case (d)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/seven_segment_frame_sequencer.sv =====
// Top level of the seven-segment frame sequencer.
`timescale 1ns / 1ps

// Each request beat (value, command) becomes a run of two to seven frame
// beats of digit select and active-low segments, the last one a blanking
// frame flagged by tlast. A request is accepted in the idle state and its
// frames are then written one after another while the output side keeps
// tready high; each digit frame divides the working value by ten through a
// reciprocal multiply. The next request is taken once the blanking frame
// sits in the output register.
module seven_segment_frame_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] digit_select, [15:8] segment_pattern
    output logic        o_m_axis_tlast
);
    import ssfs_pkg::*;

    t_ctrl      w_ctrl;
    t_stat      w_stat;
    logic [7:0] w_sel;
    logic [7:0] w_seg;

    ssfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    ssfs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_s_axis_tdata),
        .i_cmd       (i_s_axis_tuser),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_sel   (w_sel),
        .o_out_seg   (w_seg),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_seg, w_sel};

endmodule

// ===== rtl/ssfs_ctrl.sv =====
// Frame sequencing state machine for the seven-segment frame sequencer.
`timescale 1ns / 1ps

module ssfs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  ssfs_pkg::t_stat i_stat,
    output ssfs_pkg::t_ctrl o_ctrl
);
    import ssfs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a frame state can move on only when its frame is written
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    case (i_stat.cmd)
                        CMD_SLEEP:   n_state = ST_DASH;
                        CMD_DEFAULT: n_state = ST_DIGIT;
                        default:     n_state = ST_LEAD;
                    endcase
                end
            end
            ST_DASH: begin
                if (i_stat.out_free && i_stat.sel_unit) begin
                    n_state = ST_BLANK;
                end
            end
            ST_LEAD: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.value_zero ? ST_BLANK : ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_stat.out_free && i_stat.quot_zero) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_req_ready  = 1'b0;
        o_ctrl.load  = 1'b0;
        o_ctrl.emit  = 1'b0;
        o_ctrl.frame = FRAME_BLANK;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_ctrl.load = i_req_valid;
            end
            ST_DASH: begin
                o_ctrl.emit  = i_stat.out_free;
                o_ctrl.frame = FRAME_DASH;
            end
            ST_LEAD: begin
                o_ctrl.emit  = i_stat.out_free;
                o_ctrl.frame = FRAME_LEAD;
            end
            ST_DIGIT: begin
                o_ctrl.emit  = i_stat.out_free;
                o_ctrl.frame = FRAME_DIGIT;
            end
            ST_BLANK: begin
                o_ctrl.emit  = i_stat.out_free;
                o_ctrl.frame = FRAME_BLANK;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/ssfs_datapath.sv =====
// Working value, digit extraction and output frame register.
`timescale 1ns / 1ps

module ssfs_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_value,
    input  logic [1:0]      i_cmd,
    input  ssfs_pkg::t_ctrl i_ctrl,
    output ssfs_pkg::t_stat o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_sel,
    output logic [7:0]      o_out_seg,
    output logic            o_out_last
);
    import ssfs_pkg::*;

    logic [15:0] r_value;
    logic [1:0]  r_cmd;
    logic [7:0]  r_sel;
    logic        r_out_valid;
    logic [7:0]  r_out_sel;
    logic [7:0]  r_out_seg;
    logic        r_out_last;

    logic [31:0] w_prod;
    logic [15:0] w_quot;
    logic [15:0] w_quot10;
    logic [3:0]  w_rem;
    logic        w_out_free;
    logic [7:0]  w_lead_seg;

    // Divide by ten through the reciprocal; remainder is the low digit
    assign w_prod   = 32'(r_value) * 32'(RECIP10);
    assign w_quot   = 16'(w_prod[31:RECIP_SHIFT]);
    assign w_quot10 = {w_quot[12:0], 3'b000} + {w_quot[14:0], 1'b0};
    assign w_rem    = 4'(r_value - w_quot10);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_lead_seg = (r_cmd == CMD_MATCH) ? SEG_DOT : SEG_UNDERSCORE;

    // Request capture and digit walk
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_value <= i_value;
            r_cmd   <= i_cmd;
            r_sel   <= SEL_START;
        end else if (i_ctrl.emit) begin
            case (i_ctrl.frame)
                FRAME_DASH: begin
                    r_sel <= r_sel >> 1;
                end
                FRAME_DIGIT: begin
                    r_value <= w_quot;
                    r_sel   <= r_sel >> 1;
                end
                default: begin
                    r_sel <= r_sel;
                end
            endcase
        end
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            case (i_ctrl.frame)
                FRAME_DASH: begin
                    r_out_sel  <= r_sel;
                    r_out_seg  <= SEG_DASH;
                    r_out_last <= 1'b0;
                end
                FRAME_LEAD: begin
                    r_out_sel  <= SEL_UNIT;
                    r_out_seg  <= w_lead_seg;
                    r_out_last <= 1'b0;
                end
                FRAME_DIGIT: begin
                    r_out_sel  <= r_sel;
                    r_out_seg  <= digit_font(w_rem);
                    r_out_last <= 1'b0;
                end
                default: begin
                    r_out_sel  <= SEL_NONE;
                    r_out_seg  <= SEG_BLANK;
                    r_out_last <= 1'b1;
                end
            endcase
        end
    end

    // The command always comes straight from the input beat; the controller reads it only while idle
    assign o_stat.out_free   = w_out_free;
    assign o_stat.value_zero = (r_value == 16'd0);
    assign o_stat.quot_zero  = (w_quot == 16'd0);
    assign o_stat.sel_unit   = (r_sel == SEL_UNIT);
    assign o_stat.cmd        = i_cmd;

    assign o_out_valid = r_out_valid;
    assign o_out_sel   = r_out_sel;
    assign o_out_seg   = r_out_seg;
    assign o_out_last  = r_out_last;

endmodule
